>>> src/rau_pkg.sv
// shared types and constants of the rational arithmetic unit
`default_nettype none
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int OPW = OPERAND_WIDTH;
    localparam int FIELD_W = 32;
    localparam int RES_W = 64;
    localparam int KIND_W = 3;
    localparam int STATUS_W = 3;
    localparam int IN_DATA_W = 4 * FIELD_W;
    localparam int OUT_DATA_W = 2 * RES_W;
    localparam int QW = OPW + 1;
    localparam int MW = OPW + 1;
    localparam int PW = 2 * MW;
    localparam int CNT_W = $clog2(OPW);

    localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SUB = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DIV = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CMP = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SIMP = 3'd5;

    typedef enum logic [STATUS_W-1:0] {
        RS_VALID       = 3'd0,
        RS_ZERO        = 3'd1,
        RS_LESS        = 3'd2,
        RS_EQUAL       = 3'd3,
        RS_GREATER     = 3'd4,
        RS_CMP_INVALID = 3'd5,
        RS_SIMPLIFIED  = 3'd6,
        RS_INVALID     = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        DIV_GCD,
        DIV_Q1,
        DIV_Q2,
        DIV_SA,
        DIV_SB
    } div_op_t;

    typedef struct packed {
        logic                  start;
        logic signed [OPW-1:0] dividend;
        logic signed [OPW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic signed [QW-1:0]  quot;
        logic signed [OPW-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

>>> src/rau_div.sv
// iterative signed divider, one quotient bit a cycle, truncating remainder
`default_nettype none
module rau_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire rau_pkg::div_req_t req,
    output rau_pkg::div_rsp_t      rsp
);
    import rau_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OPW-1:0]   rem_reg;
    logic [OPW-1:0]   qd_reg;
    logic [OPW-1:0]   dmag_reg;
    logic             neg_q_reg;
    logic             neg_r_reg;

    logic [OPW:0]     trial;
    logic [OPW:0]     diff;
    logic             ge;
    logic [OPW-1:0]   rem_next;
    logic [QW-1:0]    qext;
    logic [OPW-1:0]   rem_mag;

    function automatic logic [OPW-1:0] mag(input logic signed [OPW-1:0] v);
        logic [OPW-1:0] r;
        r = v;
        if (v[OPW-1]) begin
            r = ~r + OPW'(1);
        end
        return r;
    endfunction

    always_comb begin
        trial    = {rem_reg, qd_reg[OPW-1]};
        diff     = trial - {1'b0, dmag_reg};
        ge       = (trial >= {1'b0, dmag_reg});
        rem_next = ge ? diff[OPW-1:0] : trial[OPW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(OPW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg   <= '0;
            qd_reg    <= mag(req.dividend);
            dmag_reg  <= mag(req.divisor);
            neg_q_reg <= req.dividend[OPW-1] ^ req.divisor[OPW-1];
            neg_r_reg <= req.dividend[OPW-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            qd_reg  <= {qd_reg[OPW-2:0], ge};
        end
    end

    always_comb begin
        qext    = {1'b0, qd_reg};
        rem_mag = rem_reg;
        rsp.done = done_reg;
        rsp.quot = neg_q_reg ? (~qext + QW'(1)) : qext;
        rsp.rem  = neg_r_reg ? (~rem_mag + OPW'(1)) : rem_mag;
    end

endmodule
`default_nettype wire

>>> src/rational_arithmetic_unit.sv
// top level of the rational arithmetic unit
//
// one request on the s_ channel carries an operation code in s_tuser and two
// fractions in s_tdata; one result leaves on the m_ channel with the status
// code in m_tuser and the result fraction in m_tdata
// add, subtract and simplify run Euclid's algorithm on the shared divider;
// the number of remainder steps is at most about 46 for 32-bit operands
// multiply, divide and compare use the single multiplier twice; an unknown
// code, or a zero denominator in add, subtract, compare or simplify, goes
// straight to the result
// the next request can be taken from the cycle in which m_tvalid rises
// s_tready is high only while no request is being worked on
// the result sits in an output register; a new request is taken while it
// waits, and a finished result waits in its last state until m_tready frees
// the register
// reset clears the sequencer and the output valid, and the block is ready
// in the first cycle after reset
`default_nettype none
module rational_arithmetic_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // a_num, a_den, b_num, b_den
    input  wire logic [rau_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind
    input  wire logic [rau_pkg::KIND_W-1:0]     s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // result_num, result_den
    output logic [rau_pkg::OUT_DATA_W-1:0]      m_tdata,
    // status
    output logic [rau_pkg::STATUS_W-1:0]        m_tuser
);
    import rau_pkg::*;

    state_t  state_reg, state_next;
    div_op_t div_op_reg;

    logic [KIND_W-1:0]       kind_reg;
    logic signed [OPW-1:0]   an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [OPW-1:0]   x_reg, y_reg;
    logic signed [QW-1:0]    q1_reg, q2_reg;
    logic signed [RES_W-1:0] p0_reg, p1_reg, p2_reg;
    logic [1:0]              mul_step_reg;

    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0]     m_tuser_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [MW-1:0]    mul_a, mul_b;
    logic signed [PW-1:0]    prod;
    logic signed [RES_W-1:0] prod_res;
    logic [1:0]              mul_last;
    logic                    is_addsub;
    logic                    is_simp;
    logic                    den_zero;
    logic                    a_den_zero;
    logic                    load_out;

    logic signed [RES_W-1:0] res_num, res_den, sum, sq_num, sq_den;
    status_t                 res_st;

    rau_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        is_addsub  = (kind_reg == KIND_ADD) || (kind_reg == KIND_SUB);
        is_simp    = (kind_reg == KIND_SIMP);
        a_den_zero = (ad_reg == '0);
        den_zero   = a_den_zero || (bd_reg == '0);
        mul_last   = is_addsub ? 2'd2 : 2'd1;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD: begin
                case (kind_reg) inside
                    KIND_ADD, KIND_SUB: state_next = den_zero ? S_DONE : S_DIV_START;
                    KIND_SIMP:          state_next = a_den_zero ? S_DONE : S_DIV_START;
                    KIND_MUL, KIND_DIV: state_next = S_MUL;
                    KIND_CMP:           state_next = den_zero ? S_DONE : S_MUL;
                    default:            state_next = S_DONE;
                endcase
            end
            S_DIV_START: begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    unique case (div_op_reg)
                        DIV_Q2:  state_next = S_MUL;
                        DIV_SB:  state_next = S_DONE;
                        default: state_next = S_DIV_START;
                    endcase
                end
            end
            S_MUL: begin
                if (mul_step_reg == mul_last) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready         = (state_reg == S_IDLE);
        load_out         = (state_reg == S_DONE) && (!m_tvalid_reg || m_tready);
        div_req.start    = (state_reg == S_DIV_START);
        div_req.divisor  = y_reg;
        unique case (div_op_reg)
            DIV_GCD: div_req.dividend = x_reg;
            DIV_Q1:  div_req.dividend = bd_reg;
            DIV_Q2:  div_req.dividend = ad_reg;
            DIV_SA:  div_req.dividend = an_reg;
            DIV_SB:  div_req.dividend = ad_reg;
            default: div_req.dividend = x_reg;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = MW'(an_reg);
        mul_b = MW'(bn_reg);
        case (kind_reg) inside
            KIND_ADD, KIND_SUB: begin
                case (mul_step_reg)
                    2'd0: begin
                        mul_a = MW'(ad_reg);
                        mul_b = q1_reg;
                    end
                    2'd1: begin
                        mul_a = q1_reg;
                        mul_b = MW'(an_reg);
                    end
                    default: begin
                        mul_a = q2_reg;
                        mul_b = MW'(bn_reg);
                    end
                endcase
            end
            KIND_MUL: begin
                mul_a = (mul_step_reg == 2'd0) ? MW'(an_reg) : MW'(ad_reg);
                mul_b = (mul_step_reg == 2'd0) ? MW'(bn_reg) : MW'(bd_reg);
            end
            KIND_DIV: begin
                mul_a = (mul_step_reg == 2'd0) ? MW'(an_reg) : MW'(ad_reg);
                mul_b = (mul_step_reg == 2'd0) ? MW'(bd_reg) : MW'(bn_reg);
            end
            KIND_CMP: begin
                mul_a = (mul_step_reg == 2'd0) ? MW'(an_reg) : MW'(bn_reg);
                mul_b = (mul_step_reg == 2'd0) ? MW'(bd_reg) : MW'(ad_reg);
            end
            default: begin
                mul_a = MW'(an_reg);
                mul_b = MW'(bn_reg);
            end
        endcase
        prod     = mul_a * mul_b;
        prod_res = RES_W'(prod);
    end

    // final result
    always_comb begin
        res_num = '0;
        res_den = '0;
        res_st  = RS_ZERO;
        sum     = (kind_reg == KIND_ADD) ? (p1_reg + p2_reg) : (p1_reg - p2_reg);
        sq_num  = RES_W'(q1_reg);
        sq_den  = RES_W'(q2_reg);
        case (kind_reg) inside
            KIND_ADD, KIND_SUB: begin
                if (!den_zero) begin
                    res_num = sum;
                    res_den = p0_reg;
                    res_st  = ((sum == '0) || (p0_reg == '0)) ? RS_ZERO : RS_VALID;
                end
            end
            KIND_MUL, KIND_DIV: begin
                res_num = p0_reg;
                res_den = p1_reg;
                res_st  = ((p0_reg == '0) || (p1_reg == '0)) ? RS_ZERO : RS_VALID;
            end
            KIND_CMP: begin
                if (den_zero) begin
                    res_st = RS_CMP_INVALID;
                end else if (p0_reg < p1_reg) begin
                    res_st = RS_LESS;
                end else if (p0_reg > p1_reg) begin
                    res_st = RS_GREATER;
                end else begin
                    res_st = RS_EQUAL;
                end
            end
            KIND_SIMP: begin
                if (a_den_zero) begin
                    res_num = RES_W'(an_reg);
                    res_den = RES_W'(ad_reg);
                    res_st  = RS_INVALID;
                end else begin
                    res_num = sq_den[RES_W-1] ? -sq_num : sq_num;
                    res_den = sq_den[RES_W-1] ? -sq_den : sq_den;
                    res_st  = RS_SIMPLIFIED;
                end
            end
            default: begin
                res_st = RS_ZERO;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {res_den, res_num};
            m_tuser_reg <= res_st;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_reg <= s_tuser;
                    an_reg   <= s_tdata[0*FIELD_W +: OPW];
                    ad_reg   <= s_tdata[1*FIELD_W +: OPW];
                    bn_reg   <= s_tdata[2*FIELD_W +: OPW];
                    bd_reg   <= s_tdata[3*FIELD_W +: OPW];
                end
            end
            S_LOAD: begin
                div_op_reg   <= DIV_GCD;
                mul_step_reg <= 2'd0;
                x_reg        <= is_simp ? an_reg : ad_reg;
                y_reg        <= is_simp ? ad_reg : bd_reg;
            end
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    unique case (div_op_reg)
                        DIV_GCD: begin
                            if (div_rsp.rem == '0) begin
                                div_op_reg <= is_simp ? DIV_SA : DIV_Q1;
                            end else begin
                                x_reg <= y_reg;
                                y_reg <= div_rsp.rem;
                            end
                        end
                        DIV_Q1: begin
                            q1_reg     <= div_rsp.quot;
                            div_op_reg <= DIV_Q2;
                        end
                        DIV_Q2: begin
                            q2_reg <= div_rsp.quot;
                        end
                        DIV_SA: begin
                            q1_reg     <= div_rsp.quot;
                            div_op_reg <= DIV_SB;
                        end
                        DIV_SB: begin
                            q2_reg <= div_rsp.quot;
                        end
                        default: begin
                            div_op_reg <= DIV_GCD;
                        end
                    endcase
                end
            end
            S_MUL: begin
                mul_step_reg <= mul_step_reg + 2'd1;
                case (mul_step_reg)
                    2'd0:    p0_reg <= prod_res;
                    2'd1:    p1_reg <= prod_res;
                    default: p2_reg <= prod_res;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

>>> src/rau_checker.sv
// port-level checks of the rational arithmetic unit and their binding
`default_nettype none
module rau_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_tvalid,
    input wire logic                           s_tready,
    input wire logic [rau_pkg::IN_DATA_W-1:0]  s_tdata,
    input wire logic [rau_pkg::KIND_W-1:0]     s_tuser,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [rau_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic [rau_pkg::STATUS_W-1:0]   m_tuser
);
    import rau_pkg::*;

    logic in_req;
    logic cmp_status;

    assign in_req     = s_tvalid && s_tready && (s_tdata == s_tdata) && (s_tuser == s_tuser);
    assign cmp_status = (m_tuser == RS_LESS) || (m_tuser == RS_EQUAL)
                     || (m_tuser == RS_GREATER) || (m_tuser == RS_CMP_INVALID);

    // ready and output valid come up clean after reset
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not ready or output valid after reset");

    // one request at a time: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        in_req |=> !s_tready)
        else $error("ready in the cycle after a request");

    // compare results carry an empty fraction
    a_cmp_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && cmp_status |-> m_tdata == '0)
        else $error("compare result with nonzero fraction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire

>>> test/rational_arithmetic_unit_tb.sv
// self-checking stream testbench for the rational arithmetic unit
`default_nettype none
module rational_arithmetic_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rau_pkg::*;

    localparam int N_RANDOM    = 1800;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_OFF    = 3000;
    localparam int HOLD_AT     = 300;
    localparam int QUIET_LO    = 1000;
    localparam int QUIET_HI    = 1200;
    localparam int DRAIN       = 100;
    localparam int MAX_REPORTS = 40;

    localparam logic [KIND_W-1:0] KIND_UNDEF_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNDEF_B = 3'd7;

    localparam int I_MIN = 32'sh8000_0000;
    localparam int I_MAX = 32'sh7fff_ffff;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] b_den;
        logic [FIELD_W-1:0] b_num;
        logic [FIELD_W-1:0] a_den;
        logic [FIELD_W-1:0] a_num;
    } rau_request_t;

    typedef struct {
        longint  num;
        longint  den;
        status_t status;
    } fraction_t;

    class fraction_scoreboard;
        fraction_t expected_fractions[$];
        int        mismatches;
        int        reported;
        int        checked;

        function new();
            mismatches = 0;
            reported   = 0;
            checked    = 0;
        endfunction

        function longint sext_operand(logic [FIELD_W-1:0] v);
            logic [63:0] t;
            t = 64'(v) << (64 - OPW);
            return $signed(t) >>> (64 - OPW);
        endfunction

        // truncating remainder, so the divisor that ends the loop keeps its sign
        function longint euclid_gcd(longint x, longint y);
            longint r;
            while (x % y != 0) begin
                r = x % y;
                x = y;
                y = r;
            end
            return y;
        endfunction

        function fraction_t predict_fraction(rau_request_t q);
            longint    an, ad, bn, bd, g, fa, fb, lhs, rhs;
            fraction_t f;
            an = sext_operand(q.a_num);
            ad = sext_operand(q.a_den);
            bn = sext_operand(q.b_num);
            bd = sext_operand(q.b_den);
            f.num = 0;
            f.den = 0;
            f.status = RS_ZERO;
            case (q.kind)
                KIND_ADD, KIND_SUB: begin
                    if (ad != 0 && bd != 0) begin
                        g = euclid_gcd(ad, bd);
                        f.den = (ad * bd) / g;
                        fa = (f.den / ad) * an;
                        fb = (f.den / bd) * bn;
                        f.num = (q.kind == KIND_ADD) ? fa + fb : fa - fb;
                        f.status = (f.num == 0 || f.den == 0) ? RS_ZERO : RS_VALID;
                    end
                end
                KIND_MUL, KIND_DIV: begin
                    if (q.kind == KIND_MUL) begin
                        f.num = an * bn;
                        f.den = ad * bd;
                    end else begin
                        f.num = an * bd;
                        f.den = ad * bn;
                    end
                    f.status = (f.num == 0 || f.den == 0) ? RS_ZERO : RS_VALID;
                end
                KIND_CMP: begin
                    if (ad == 0 || bd == 0) begin
                        f.status = RS_CMP_INVALID;
                    end else begin
                        lhs = an * bd;
                        rhs = bn * ad;
                        f.status = (lhs < rhs) ? RS_LESS : (lhs > rhs) ? RS_GREATER : RS_EQUAL;
                    end
                end
                KIND_SIMP: begin
                    if (ad == 0) begin
                        f.num = an;
                        f.den = ad;
                        f.status = RS_INVALID;
                    end else begin
                        g = euclid_gcd(an, ad);
                        f.num = an / g;
                        f.den = ad / g;
                        if (f.den < 0) begin
                            f.num = -f.num;
                            f.den = -f.den;
                        end
                        f.status = RS_SIMPLIFIED;
                    end
                end
                default: begin
                end
            endcase
            return f;
        endfunction

        function void note_request(rau_request_t q);
            expected_fractions.push_back(predict_fraction(q));
        endfunction

        function void report(string what, longint want, longint got);
            mismatches++;
            if (reported < MAX_REPORTS) begin
                reported++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
            end
        endfunction

        function void check_result(fraction_t got);
            fraction_t want;
            checked++;
            if (expected_fractions.size() == 0) begin
                mismatches++;
                if (reported < MAX_REPORTS) begin
                    reported++;
                    $display("%0t: result %h/%h status %0d with no request outstanding",
                             $time, got.num, got.den, got.status);
                end
                return;
            end
            want = expected_fractions.pop_front();
            if (got.num != want.num)
                report("numerator", want.num, got.num);
            if (got.den != want.den)
                report("denominator", want.den, got.den);
            if (got.status != want.status)
                report("status", longint'(want.status), longint'(got.status));
        endfunction

        function int pending();
            return expected_fractions.size();
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [IN_DATA_W-1:0]    s_tdata;
    logic [KIND_W-1:0]       s_tuser;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    fraction_scoreboard sb;
    rau_request_t       directed_q[$];
    int                 kind_seen[8];
    int                 requests_taken;
    int                 idle_cycles;

    rational_arithmetic_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic rau_request_t mk(logic [KIND_W-1:0] k, int an, int ad, int bn, int bd);
        rau_request_t q;
        q.kind  = k;
        q.a_num = an;
        q.a_den = ad;
        q.b_num = bn;
        q.b_den = bd;
        return q;
    endfunction

    // mostly short, now and then long
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        return $urandom_range(30, 200);
    endfunction

    function automatic logic [FIELD_W-1:0] rand_operand();
        int unsigned r;
        logic [FIELD_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            v = $urandom;
        end else if (r < 70) begin
            v = 32'($urandom_range(0, 512)) - 32'd256;
        end else if (r < 85) begin
            case ($urandom_range(0, 4))
                0: v = '0;
                1: v = 32'd1;
                2: v = '1;
                3: v = I_MIN;
                default: v = I_MAX;
            endcase
        end else begin
            // shared small factors keep the gcd interesting
            v = 32'($urandom_range(1, 64)) * 32'($urandom_range(0, 65536));
            if ($urandom_range(0, 1) == 1)
                v = -v;
        end
        return v;
    endfunction

    function automatic rau_request_t rand_request();
        rau_request_t q;
        if ($urandom_range(0, 99) < 94)
            q.kind = 3'($urandom_range(0, 5));
        else
            q.kind = ($urandom_range(0, 1) == 1) ? KIND_UNDEF_B : KIND_UNDEF_A;
        q.a_num = rand_operand();
        q.a_den = rand_operand();
        q.b_num = rand_operand();
        q.b_den = rand_operand();
        return q;
    endfunction

    task automatic send_request(rau_request_t q, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q.b_den, q.b_num, q.a_den, q.a_num};
        s_tuser  <= q.kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_request(mk(s_tuser, s_tdata[31:0], s_tdata[63:32],
                               s_tdata[95:64], s_tdata[127:96]));
            kind_seen[s_tuser]++;
            requests_taken++;
        end
        if (aresetn && m_tvalid && m_tready)
            sb.check_result('{num: m_tdata[63:0], den: m_tdata[127:64],
                              status: status_t'(m_tuser)});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCH_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $time, WATCH_LIMIT);
            $display("rational_arithmetic_unit_tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver, with one long hold-off so the block backs up onto its input
    initial begin : receiver
        int stall;
        int n;
        n = 0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (n == HOLD_AT)
                stall = HOLD_OFF;
            else if (n >= QUIET_LO && n < QUIET_HI)
                stall = 0;
            else
                stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            n++;
        end
    end

    initial begin : sender
        int i;
        sb = new();
        requests_taken = 0;
        idle_cycles = 0;
        foreach (kind_seen[k])
            kind_seen[k] = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_ADD;

        directed_q.push_back(mk(KIND_ADD, 1, 2, 1, 3));
        directed_q.push_back(mk(KIND_SUB, 3, -4, 5, 6));
        directed_q.push_back(mk(KIND_ADD, I_MAX, I_MIN, I_MIN, I_MAX));
        directed_q.push_back(mk(KIND_ADD, 5, 0, 1, 2));
        directed_q.push_back(mk(KIND_SUB, 1, 2, 3, 0));
        directed_q.push_back(mk(KIND_ADD, 1, 2, -1, 2));
        directed_q.push_back(mk(KIND_ADD, 1, 1836311903, 1, 1134903170));
        directed_q.push_back(mk(KIND_MUL, I_MIN, I_MIN, I_MIN, I_MIN));
        directed_q.push_back(mk(KIND_MUL, 0, 3, 4, 5));
        directed_q.push_back(mk(KIND_MUL, I_MAX, -1, -1, I_MAX));
        directed_q.push_back(mk(KIND_DIV, 3, 4, 5, 7));
        directed_q.push_back(mk(KIND_DIV, 3, 4, 0, 5));
        directed_q.push_back(mk(KIND_CMP, 1, 3, 1, 2));
        directed_q.push_back(mk(KIND_CMP, 2, 4, 1, 2));
        directed_q.push_back(mk(KIND_CMP, 1, 2, 1, 3));
        directed_q.push_back(mk(KIND_CMP, 1, -2, 1, 3));
        directed_q.push_back(mk(KIND_CMP, 1, 0, 1, 2));
        directed_q.push_back(mk(KIND_CMP, I_MIN, I_MAX, I_MAX, I_MIN));
        directed_q.push_back(mk(KIND_SIMP, 6, -8, 0, 0));
        directed_q.push_back(mk(KIND_SIMP, 0, -5, I_MAX, I_MIN));
        directed_q.push_back(mk(KIND_SIMP, 5, 0, 1, 1));
        directed_q.push_back(mk(KIND_SIMP, I_MIN, -1, 0, 0));
        directed_q.push_back(mk(KIND_SIMP, I_MIN, I_MIN, -1, -1));
        directed_q.push_back(mk(KIND_UNDEF_A, 1, 2, 3, 4));
        directed_q.push_back(mk(KIND_UNDEF_B, -1, -1, -1, -1));

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_q[d])
            send_request(directed_q[d], pick_gap());
        for (i = 0; i < N_RANDOM; i++)
            send_request(rand_request(), (i >= QUIET_LO && i < QUIET_HI) ? 0 : pick_gap());
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);

        $display("%0d requests taken (%0d directed), %0d results checked, %0d mismatches",
                 requests_taken, directed_q.size(), sb.checked, sb.mismatches);
        $display("add %0d sub %0d mul %0d div %0d cmp %0d simp %0d undefined %0d, one long output stall",
                 kind_seen[KIND_ADD], kind_seen[KIND_SUB], kind_seen[KIND_MUL],
                 kind_seen[KIND_DIV], kind_seen[KIND_CMP], kind_seen[KIND_SIMP],
                 kind_seen[KIND_UNDEF_A] + kind_seen[KIND_UNDEF_B]);
        if (sb.mismatches == 0) begin
            $display("rational_arithmetic_unit_tb: clean");
        end else begin
            $display("rational_arithmetic_unit_tb: errors");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> filelist.f
src/rau_pkg.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
src/rau_checker.sv
test/rational_arithmetic_unit_tb.sv
